// File: src/lppr_pkg.sv
// ----------------------------------------------------------------------------
// lppr_pkg: shared types and constants for the length-prefixed packet ring
// Ring geometry, command and reason codes, beat structs and pointer helpers.
// ----------------------------------------------------------------------------
package lppr_pkg;

    // Ring geometry
    localparam int RING_BYTES = 262144;
    localparam int PTR_W      = $clog2(RING_BYTES);
    localparam int CNT_W      = $clog2(RING_BYTES + 1);
    // room check: fill + header + longest length must fit
    localparam int SUM_W      = $clog2(RING_BYTES + 65538);
    localparam int FILL_W     = 19;
    localparam int HDR_BYTES  = 2;

    // Register reset values
    localparam logic [7:0]  DEFAULT_KIND  = 8'd1;
    localparam logic [15:0] DEFAULT_LIMIT = 16'd1276;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [SUM_W-1:0] t_sum;

    typedef enum logic [1:0] {
        CMD_MSG  = 2'd0,
        CMD_POP  = 2'd1,
        CMD_DROP = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        RSN_NONE   = 3'd0,
        RSN_KIND   = 3'd1,
        RSN_LENGTH = 3'd2,
        RSN_TRUNC  = 3'd3,
        RSN_ROOM   = 3'd4
    } t_reason;

    typedef enum logic [2:0] {
        PH_KIND,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY,
        PH_SKIP,
        PH_REJECT
    } t_parse_phase;

    typedef enum logic [1:0] {
        POP_IDLE,
        POP_HDR,
        POP_BODY
    } t_pop_phase;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_POP
    } t_seq_state;

    typedef enum logic {
        REG_ACCEPTED_KIND = 1'b0,
        REG_PACKET_LIMIT  = 1'b1
    } t_cfg_reg;

    // Input beat
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] msg_byte;
        logic       last_of_message;
    } t_item;

    // Result beat
    typedef struct packed {
        logic              data_valid;
        logic [7:0]        data_byte;
        logic              data_last;
        logic              pop_empty;
        logic              message_done;
        logic              message_ok;
        logic [2:0]        reject_reason;
        logic              pending;
        logic [FILL_W-1:0] fill_count;
    } t_result;

    // Ring write request
    typedef struct packed {
        logic       we;
        t_ptr       addr;
        logic [7:0] data;
    } t_wr_req;

    // Entry commit from the parser
    typedef struct packed {
        logic        commit;
        logic [15:0] len;
    } t_commit;

    // Message end status from the parser
    typedef struct packed {
        logic       done;
        logic       ok;
        logic [2:0] reason;
    } t_msg_status;

    // Next ring position with wrap
    function automatic t_ptr ptr_adv(input t_ptr p);
        t_ptr q;
        if (p == t_ptr'(RING_BYTES - 1)) begin
            q = '0;
        end else begin
            q = p + t_ptr'(1);
        end
        return q;
    endfunction

    // Low bits of the fill count as reported
    function automatic logic [FILL_W-1:0] fill_of(input t_cnt c);
        logic [CNT_W+FILL_W-1:0] w;
        w = {{FILL_W{1'b0}}, c};
        return w[FILL_W-1:0];
    endfunction

endpackage

// File: src/length_prefixed_packet_ring_fifo.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_fifo: packet ring with length-prefixed entries
// Parses messages into a byte ring, pops stored packets byte by byte and
// reports fill and message status on every result.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------
//  command   | start / busy           | i_item   (cmd, msg_byte, last)
//  result    | o_done strobe, no stall| o_result (status, data, fill)
//  config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
//  The byte that completes an accepted length header holds busy while the
//  second header byte is written unless it also ends the message, since both
//  header bytes share the ring write port. A pop that reads the ring passes
//  through SEQ_POP for the registered ram read; empty pops, drops and no-ops
//  do not. The result strobe is high in the cycle after the accepting edge,
//  or after the ring read cycle for a pop. Reset is synchronous; ring contents
//  are not cleared, only pointers and counts, so no clearing pass is needed.
//
module length_prefixed_packet_ring_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lppr_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output logic              o_done,
    output lppr_pkg::t_result o_result
);

    lppr_pkg::t_seq_state  r_seq, n_seq;
    lppr_pkg::t_pop_phase  r_pop_phase, n_pop_phase;
    logic [15:0]           r_pop_rem, n_pop_rem;
    lppr_pkg::t_ptr        r_rp, n_rp;
    lppr_pkg::t_cnt        r_cnt, n_cnt;
    logic                  r_done, n_done;
    lppr_pkg::t_result     r_res, n_res;
    logic [7:0]            r_kind;
    logic [15:0]           r_limit;

    logic                  accept;
    logic                  msg_step;
    logic                  rd_en;
    logic [7:0]            rd_data;
    logic [15:0]           hdr_len;
    logic [15:0]           rem_dec;
    lppr_pkg::t_wr_req     wr;
    lppr_pkg::t_commit     commit;
    lppr_pkg::t_msg_status msg_status;
    lppr_pkg::t_ptr        wp;
    logic                  hdr_busy;

    assign busy     = (r_seq != lppr_pkg::SEQ_IDLE) || hdr_busy;
    assign accept   = start && !busy;
    assign msg_step = accept && (i_item.cmd == lppr_pkg::CMD_MSG);
    assign hdr_len  = {rd_data, r_pop_rem[7:0]};
    assign rem_dec  = (r_pop_rem != '0) ? (r_pop_rem - 16'd1) : '0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= lppr_pkg::DEFAULT_KIND;
            r_limit <= lppr_pkg::DEFAULT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lppr_pkg::REG_ACCEPTED_KIND: r_kind  <= i_cfg_data[7:0];
                lppr_pkg::REG_PACKET_LIMIT:  r_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // parser and tentative writer
    lppr_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (msg_step),
        .i_byte     (i_item.msg_byte),
        .i_last     (i_item.last_of_message),
        .i_kind     (r_kind),
        .i_limit    (r_limit),
        .i_cnt      (r_cnt),
        .o_wr       (wr),
        .o_commit   (commit),
        .o_status   (msg_status),
        .o_wp       (wp),
        .o_hdr_busy (hdr_busy)
    );

    // byte ring
    lppr_ram #(
        .WIDTH (8),
        .DEPTH (lppr_pkg::RING_BYTES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd_en),
        .i_raddr (r_rp),
        .o_rdata (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= lppr_pkg::SEQ_IDLE;
            r_pop_phase <= lppr_pkg::POP_IDLE;
            r_pop_rem   <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_pop_phase <= n_pop_phase;
            r_pop_rem   <= n_pop_rem;
            r_rp        <= n_rp;
            r_cnt       <= n_cnt;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // command sequencing, pop reader and result build
    always_comb begin
        n_seq       = r_seq;
        n_pop_phase = r_pop_phase;
        n_pop_rem   = r_pop_rem;
        n_rp        = r_rp;
        n_cnt       = r_cnt;
        n_done      = 1'b0;
        n_res       = '0;
        rd_en       = 1'b0;

        case (r_seq)
            lppr_pkg::SEQ_IDLE: begin
                if (accept) begin
                    n_done = 1'b1;
                    case (i_item.cmd)
                        lppr_pkg::CMD_MSG: begin
                            if (commit.commit) begin
                                n_cnt = r_cnt + lppr_pkg::t_cnt'(commit.len)
                                      + lppr_pkg::t_cnt'(lppr_pkg::HDR_BYTES);
                            end
                            n_res.message_done  = msg_status.done;
                            n_res.message_ok    = msg_status.ok;
                            n_res.reject_reason = msg_status.reason;
                        end
                        lppr_pkg::CMD_POP: begin
                            if (r_pop_phase == lppr_pkg::POP_IDLE) begin
                                if (r_cnt < lppr_pkg::t_cnt'(2)) begin
                                    n_res.pop_empty = 1'b1;
                                end else begin
                                    rd_en  = 1'b1;
                                    n_done = 1'b0;
                                    n_seq  = lppr_pkg::SEQ_POP;
                                end
                            end else if (r_cnt == '0) begin
                                n_res.pop_empty = 1'b1;
                                n_pop_phase     = lppr_pkg::POP_IDLE;
                                n_pop_rem       = '0;
                            end else begin
                                rd_en  = 1'b1;
                                n_done = 1'b0;
                                n_seq  = lppr_pkg::SEQ_POP;
                            end
                        end
                        lppr_pkg::CMD_DROP: begin
                            n_rp        = wp;
                            n_cnt       = '0;
                            n_pop_phase = lppr_pkg::POP_IDLE;
                            n_pop_rem   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lppr_pkg::SEQ_POP: begin
                // ring byte is back: consume it
                n_done = 1'b1;
                n_seq  = lppr_pkg::SEQ_IDLE;
                n_rp   = lppr_pkg::ptr_adv(r_rp);
                n_cnt  = r_cnt - lppr_pkg::t_cnt'(1);
                case (r_pop_phase)
                    lppr_pkg::POP_IDLE: begin
                        n_pop_rem   = {8'd0, rd_data};
                        n_pop_phase = lppr_pkg::POP_HDR;
                    end
                    lppr_pkg::POP_HDR: begin
                        n_pop_rem   = hdr_len;
                        n_pop_phase = (hdr_len == '0) ? lppr_pkg::POP_IDLE
                                                      : lppr_pkg::POP_BODY;
                    end
                    default: begin
                        n_res.data_valid = 1'b1;
                        n_res.data_byte  = rd_data;
                        n_pop_rem        = rem_dec;
                        if (rem_dec == '0) begin
                            n_res.data_last = 1'b1;
                            n_pop_phase     = lppr_pkg::POP_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                n_seq = lppr_pkg::SEQ_IDLE;
            end
        endcase

        n_res.pending    = (n_cnt >= lppr_pkg::t_cnt'(2));
        n_res.fill_count = lppr_pkg::fill_of(n_cnt);
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// File: src/lppr_ram.sv
// ----------------------------------------------------------------------------
// lppr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: src/lppr_parse.sv
// ----------------------------------------------------------------------------
// lppr_parse: message parser and tentative ring writer
// Walks kind, length and body bytes, checks each entry, writes it into the
// ring past the write pointer and commits it on its final byte.
// ----------------------------------------------------------------------------
module lppr_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [7:0]           i_kind,
    input  logic [15:0]          i_limit,
    input  lppr_pkg::t_cnt       i_cnt,
    output lppr_pkg::t_wr_req    o_wr,
    output lppr_pkg::t_commit    o_commit,
    output lppr_pkg::t_msg_status o_status,
    output lppr_pkg::t_ptr       o_wp,
    output logic                 o_hdr_busy
);

    lppr_pkg::t_parse_phase r_phase, n_phase;
    lppr_pkg::t_reason      r_fail, n_fail;
    logic [15:0]            r_len, n_len;
    logic [15:0]            r_rem, n_rem;
    lppr_pkg::t_ptr         r_tent, n_tent;
    lppr_pkg::t_ptr         r_wp, n_wp;
    logic                   r_hdr_pend, n_hdr_pend;
    logic [7:0]             r_hdr_byte, n_hdr_byte;

    logic [15:0]            len_full;
    logic [15:0]            rem_dec;
    lppr_pkg::t_sum         room_need;
    lppr_pkg::t_reason      reason;

    assign len_full  = {i_byte, r_len[7:0]};
    assign rem_dec   = r_rem - 16'd1;
    assign room_need = lppr_pkg::t_sum'(i_cnt) + lppr_pkg::t_sum'(len_full)
                     + lppr_pkg::t_sum'(lppr_pkg::HDR_BYTES);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lppr_pkg::PH_KIND;
            r_fail     <= lppr_pkg::RSN_NONE;
            r_len      <= '0;
            r_rem      <= '0;
            r_tent     <= '0;
            r_wp       <= '0;
            r_hdr_pend <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_fail     <= n_fail;
            r_len      <= n_len;
            r_rem      <= n_rem;
            r_tent     <= n_tent;
            r_wp       <= n_wp;
            r_hdr_pend <= n_hdr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr_byte <= n_hdr_byte;
    end

    // parse step
    always_comb begin
        n_phase    = r_phase;
        n_fail     = r_fail;
        n_len      = r_len;
        n_rem      = r_rem;
        n_tent     = r_tent;
        n_wp       = r_wp;
        n_hdr_pend = 1'b0;
        n_hdr_byte = r_hdr_byte;
        o_wr       = '0;
        o_commit   = '0;
        o_status   = '0;
        reason     = lppr_pkg::RSN_NONE;

        // second header byte goes out the cycle after the first
        if (r_hdr_pend) begin
            o_wr.we   = 1'b1;
            o_wr.addr = r_tent;
            o_wr.data = r_hdr_byte;
            n_tent    = lppr_pkg::ptr_adv(r_tent);
        end

        if (i_step) begin
            case (r_phase)
                lppr_pkg::PH_KIND: begin
                    if (i_byte != i_kind) begin
                        n_fail  = lppr_pkg::RSN_KIND;
                        n_phase = lppr_pkg::PH_REJECT;
                    end else begin
                        n_phase = lppr_pkg::PH_LEN_LO;
                    end
                end
                lppr_pkg::PH_LEN_LO: begin
                    n_len   = {8'd0, i_byte};
                    n_phase = lppr_pkg::PH_LEN_HI;
                end
                lppr_pkg::PH_LEN_HI: begin
                    n_len = len_full;
                    if (len_full == '0 || len_full > i_limit) begin
                        n_fail  = lppr_pkg::RSN_LENGTH;
                        n_phase = lppr_pkg::PH_REJECT;
                    end else if (room_need > lppr_pkg::t_sum'(lppr_pkg::RING_BYTES)) begin
                        n_rem   = len_full;
                        n_phase = lppr_pkg::PH_SKIP;
                    end else begin
                        n_rem   = len_full;
                        n_phase = lppr_pkg::PH_BODY;
                        // header bytes land only if the entry can go on
                        if (!i_last) begin
                            o_wr.we    = 1'b1;
                            o_wr.addr  = r_wp;
                            o_wr.data  = r_len[7:0];
                            n_tent     = lppr_pkg::ptr_adv(r_wp);
                            n_hdr_pend = 1'b1;
                            n_hdr_byte = i_byte;
                        end
                    end
                end
                lppr_pkg::PH_BODY: begin
                    o_wr.we   = 1'b1;
                    o_wr.addr = r_tent;
                    o_wr.data = i_byte;
                    n_tent    = lppr_pkg::ptr_adv(r_tent);
                    n_rem     = rem_dec;
                    if (rem_dec == '0) begin
                        n_wp            = lppr_pkg::ptr_adv(r_tent);
                        o_commit.commit = 1'b1;
                        o_commit.len    = r_len;
                        n_phase         = lppr_pkg::PH_LEN_LO;
                    end
                end
                lppr_pkg::PH_SKIP: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_fail  = lppr_pkg::RSN_ROOM;
                        n_phase = lppr_pkg::PH_REJECT;
                    end
                end
                default: begin
                end
            endcase

            // message end: report and rearm
            if (i_last) begin
                if (n_phase == lppr_pkg::PH_REJECT) begin
                    reason = n_fail;
                end else if (n_phase == lppr_pkg::PH_BODY || n_phase == lppr_pkg::PH_SKIP) begin
                    reason = lppr_pkg::RSN_TRUNC;
                end else begin
                    reason = lppr_pkg::RSN_NONE;
                end
                o_status.done   = 1'b1;
                o_status.ok     = (reason == lppr_pkg::RSN_NONE);
                o_status.reason = reason;
                n_phase         = lppr_pkg::PH_KIND;
                n_fail          = lppr_pkg::RSN_NONE;
                n_len           = '0;
                n_rem           = '0;
            end
        end
    end

    assign o_wp       = r_wp;
    assign o_hdr_busy = r_hdr_pend;

endmodule

// File: src/lppr_checker.sv
// ----------------------------------------------------------------------------
// lppr_checker: port-level checks for the packet ring
// Watches the command and result beats seen at the top level ports.
// ----------------------------------------------------------------------------
module lppr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input lppr_pkg::t_item   i_item,
    input logic              o_done,
    input lppr_pkg::t_result o_result
);

    // a result beat carries at most one kind of outcome
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0({o_result.data_valid, o_result.pop_empty,
                             o_result.message_done}))
        else $error("result beat mixes pop data, empty pop and message status");

    // ok only on a message end with no reason
    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.message_ok) |->
            (o_result.message_done && o_result.reject_reason == 3'd0))
        else $error("message_ok with a reject reason or without message_done");

    // last byte mark only on packet data
    a_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.data_last) |-> o_result.data_valid)
        else $error("data_last without data_valid");

    // a drop reports an empty ring on the very next beat
    a_drop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == lppr_pkg::CMD_DROP) |=>
            (o_done && o_result.fill_count == '0 && !o_result.pending))
        else $error("drop did not report an empty ring");

    // every result follows an accepted command or a busy cycle
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe with no command behind it");

endmodule

bind length_prefixed_packet_ring_fifo lppr_checker u_lppr_checker (.*);
